[rtl/albm_pkg.sv]
// Shared types and constants for the ambient light brightness map.
// Holds status codes, register indexes, fixed-point constants and stage controls.
// No dependencies.
`timescale 1ns / 1ps

package albm_pkg;

  // Reading status codes
  localparam logic [1:0] STATUS_VALID      = 2'd0;
  localparam logic [1:0] STATUS_NOT_READY  = 2'd1;
  localparam logic [1:0] STATUS_SATURATION = 2'd2;
  localparam logic [1:0] STATUS_OVERFLOW   = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_MAX_LEVEL        = 2'd0;
  localparam logic [1:0] REG_MIN_LEVEL        = 2'd1;
  localparam logic [1:0] REG_FULL_SCALE_COUNT = 2'd2;

  localparam logic [7:0]  MAX_LEVEL_RESET  = 8'd255;
  localparam logic [7:0]  MIN_LEVEL_RESET  = 8'd30;
  localparam logic [15:0] FULL_SCALE_RESET = 16'd1000;

  localparam logic [15:0] MIN_COUNT  = 16'd10;
  localparam logic [15:0] FULL_COUNT = 16'd65535;

  // ln2 in Q16
  localparam logic signed [16:0] LN2_Q16 = 17'sd45426;

  // (2^18 + 1) / 5: count/5 is the product >> 18, count/10 the product >> 19
  localparam logic [15:0] RECIP_FIFTH = 16'd52429;

  localparam int NUM_STAGES = 7;

  // Load enables for the stages shared by the log2 and window units
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } stage_load_t;

endpackage

[rtl/albm_log2.sv]
// Three-stage fixed-point log2 of a 16-bit value, result in Q16.
// Leading-one position plus interpolated fraction table; depends on albm_pkg.
`timescale 1ns / 1ps

module albm_log2 #(
  parameter int LOG_TABLE_ENTRIES = 32
) (
  input  logic                 clk,
  input  albm_pkg::stage_load_t load,
  input  logic [15:0]          value,
  output logic [20:0]          log2_q16
);
  import albm_pkg::*;

  localparam int ROM_AW = $clog2(LOG_TABLE_ENTRIES + 1);
  localparam int POS_W  = 15 + ROM_AW;

  // log2(1 + i/N) in Q16, rounded to nearest; evaluated at elaboration only
  function automatic logic [16:0] frac_log2(input int unsigned i);
    logic [63:0] x;
    logic [63:0] acc;
    if (i >= LOG_TABLE_ENTRIES) begin
      return 17'd65536;
    end
    acc = 64'd0;
    x = (64'd1 << 30) + ((64'(i) << 30) / LOG_TABLE_ENTRIES);
    for (int b = 0; b < 20; b++) begin
      x = (x * x) >> 30;
      acc = acc << 1;
      if (x >= (64'd1 << 31)) begin
        acc = acc | 64'd1;
        x = x >> 1;
      end
    end
    return 17'((acc + 64'd8) >> 4);
  endfunction

  logic [16:0] frac_rom [0:LOG_TABLE_ENTRIES];

  for (genvar g = 0; g <= LOG_TABLE_ENTRIES; g++) begin : g_rom
    assign frac_rom[g] = frac_log2(g);
  end

  // Stage 2: leading one, normalise, scale fraction by table size
  logic [3:0]       msb;
  logic [15:0]      norm;
  logic [POS_W-1:0] pos;
  logic [3:0]       msb_s2;

  always_comb begin
    msb = 4'd0;
    for (int k = 0; k < 16; k++) begin
      if (value[k]) begin
        msb = 4'(k);
      end
    end
    norm = value << (4'd15 - msb);
  end

  always_ff @(posedge clk) begin
    if (load.s2) begin
      pos    <= POS_W'(norm[14:0]) * POS_W'(LOG_TABLE_ENTRIES);
      msb_s2 <= msb;
    end
  end

  // Stage 3: table lookup and interpolation product
  logic [ROM_AW-1:0] idx;
  logic [ROM_AW-1:0] idx_hi;
  logic [14:0]       rem;
  logic [16:0]       lo;
  logic [16:0]       hi;
  logic [16:0]       lo_s3;
  logic [31:0]       prod_s3;
  logic [3:0]        msb_s3;

  assign idx    = pos[POS_W-1:15];
  assign idx_hi = idx + ROM_AW'(1);
  assign rem    = pos[14:0];
  assign lo     = frac_rom[idx];
  assign hi     = frac_rom[idx_hi];

  always_ff @(posedge clk) begin
    if (load.s3) begin
      lo_s3   <= lo;
      prod_s3 <= 32'(hi - lo) * 32'(rem);
      msb_s3  <= msb_s2;
    end
  end

  // Stage 4: integer part plus interpolated fraction
  always_ff @(posedge clk) begin
    if (load.s4) begin
      log2_q16 <= {1'b0, msb_s3, 16'd0} + 21'(lo_s3) + 21'(prod_s3[31:15]);
    end
  end

endmodule

[rtl/albm_window.sv]
// Three-stage interrupt window: count - count/5 and count + count/10, the latter saturated.
// Divides by reciprocal multiplication; depends on albm_pkg.
`timescale 1ns / 1ps

module albm_window (
  input  logic                 clk,
  input  albm_pkg::stage_load_t load,
  input  logic [15:0]          count,
  output logic [15:0]          low_threshold,
  output logic [15:0]          high_threshold
);
  import albm_pkg::*;

  logic [31:0] recip_prod;
  logic [15:0] count_s2;
  logic [15:0] low_s3;
  logic [16:0] high_sum_s3;

  always_ff @(posedge clk) begin
    if (load.s2) begin
      recip_prod <= 32'(count) * 32'(RECIP_FIFTH);
      count_s2   <= count;
    end
  end

  always_ff @(posedge clk) begin
    if (load.s3) begin
      low_s3      <= count_s2 - 16'(recip_prod[31:18]);
      high_sum_s3 <= 17'(count_s2) + 17'(recip_prod[31:19]);
    end
  end

  // Saturate the upper bound at full count
  always_ff @(posedge clk) begin
    if (load.s4) begin
      low_threshold  <= low_s3;
      high_threshold <= high_sum_s3[16] ? FULL_COUNT : high_sum_s3[15:0];
    end
  end

endmodule

[rtl/ambient_light_brightness_map.sv]
// Top level of the ambient light brightness map: handshake, stage control,
// log scaling and clamp. Depends on albm_pkg, albm_log2 and albm_window.
// Seven register stages; stage 7 is the output register. Throughput: one reading per
// cycle while result_ready is high; a full stage holds while the stage after it holds.
// Reset clears all stage valid bits and loads the register defaults.
`timescale 1ns / 1ps

module ambient_light_brightness_map #(
  parameter int LOG_TABLE_ENTRIES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic [15:0] light_count,
  input  logic [1:0]  reading_status,
  output logic        result_valid,
  input  logic        result_ready,
  output logic        update_valid,
  output logic [7:0]  brightness,
  output logic [15:0] low_threshold,
  output logic [15:0] high_threshold,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import albm_pkg::*;

  localparam logic signed [47:0] ONE_Q32   = 48'sd1 <<< 32;
  localparam logic signed [47:0] LIMIT_Q32 = 48'sd255 <<< 32;
  localparam logic signed [38:0] BIAS_Q32  = 39'sd1 <<< 32;

  // Configuration registers
  logic [7:0]  max_level;
  logic [7:0]  min_level;
  logic [15:0] full_scale_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_level        <= MAX_LEVEL_RESET;
      min_level        <= MIN_LEVEL_RESET;
      full_scale_count <= FULL_SCALE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAX_LEVEL:        max_level        <= cfg_data[7:0];
        REG_MIN_LEVEL:        min_level        <= cfg_data[7:0];
        REG_FULL_SCALE_COUNT: full_scale_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage control: a stage takes new data when empty or when it is moving on
  logic [NUM_STAGES:1]   valid;
  logic [NUM_STAGES:1]   adv;
  logic [NUM_STAGES-1:1] not_ready;
  stage_load_t           load;

  always_comb begin
    adv[NUM_STAGES] = !valid[NUM_STAGES] || result_ready;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      adv[k] = !valid[k] || adv[k+1];
    end
  end

  assign item_ready = adv[1];
  assign load.s2    = adv[2];
  assign load.s3    = adv[3];
  assign load.s4    = adv[4];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (adv[1]) begin
        valid[1] <= item_valid;
      end
      for (int k = 2; k <= NUM_STAGES; k++) begin
        if (adv[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  // Not-ready flag travels with each transaction
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      not_ready[1] <= (reading_status == STATUS_NOT_READY);
    end
    for (int k = 2; k < NUM_STAGES; k++) begin
      if (adv[k]) begin
        not_ready[k] <= not_ready[k-1];
      end
    end
  end

  // Stage 1: force full scale, raise small counts, guard a zero full scale
  logic [15:0] count_s1;
  logic [15:0] fs_s1;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      if (reading_status inside {STATUS_SATURATION, STATUS_OVERFLOW}) begin
        count_s1 <= FULL_COUNT;
      end else if (light_count < MIN_COUNT) begin
        count_s1 <= MIN_COUNT;
      end else begin
        count_s1 <= light_count;
      end
      fs_s1 <= (full_scale_count == 16'd0) ? 16'd1 : full_scale_count;
    end
  end

  // Stages 2 to 4
  logic [20:0] log_count_s4;
  logic [20:0] log_fs_s4;
  logic [15:0] low_s4;
  logic [15:0] high_s4;

  albm_log2 #(.LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES)) u_log_count (
    .clk      (clk),
    .load     (load),
    .value    (count_s1),
    .log2_q16 (log_count_s4)
  );

  albm_log2 #(.LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES)) u_log_fs (
    .clk      (clk),
    .load     (load),
    .value    (fs_s1),
    .log2_q16 (log_fs_s4)
  );

  albm_window u_window (
    .clk            (clk),
    .load           (load),
    .count          (count_s1),
    .low_threshold  (low_s4),
    .high_threshold (high_s4)
  );

  // Stage 5: natural log of the count to full scale ratio, plus one, in Q32
  logic signed [21:0] log_diff;
  logic signed [38:0] ln_s5;
  logic [15:0]        low_s5;
  logic [15:0]        high_s5;

  assign log_diff = $signed({1'b0, log_count_s4}) - $signed({1'b0, log_fs_s4});

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      ln_s5   <= log_diff * LN2_Q16 + BIAS_Q32;
      low_s5  <= low_s4;
      high_s5 <= high_s4;
    end
  end

  // Stage 6: scale by the level span and add the offset
  logic signed [8:0]  slope;
  logic signed [47:0] min_term;
  logic signed [47:0] level_s6;
  logic [15:0]        low_s6;
  logic [15:0]        high_s6;

  assign slope    = $signed({1'b0, max_level}) - $signed({1'b0, min_level});
  assign min_term = $signed({8'd0, min_level, 32'd0});

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      level_s6 <= ln_s5 * slope + min_term;
      low_s6   <= low_s5;
      high_s6  <= high_s5;
    end
  end

  // Stage 7: truncate and clamp into the output register, or zero a not-ready result
  logic [7:0] level_clamped;

  always_comb begin
    if (level_s6 < ONE_Q32) begin
      level_clamped = 8'd1;
    end else if (level_s6 >= LIMIT_Q32) begin
      level_clamped = 8'd255;
    end else begin
      level_clamped = level_s6[39:32];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[NUM_STAGES]) begin
      if (not_ready[NUM_STAGES-1]) begin
        update_valid   <= 1'b0;
        brightness     <= 8'd0;
        low_threshold  <= 16'd0;
        high_threshold <= 16'd0;
      end else begin
        update_valid   <= 1'b1;
        brightness     <= level_clamped;
        low_threshold  <= low_s6;
        high_threshold <= high_s6;
      end
    end
  end

  assign result_valid = valid[NUM_STAGES];

endmodule

[rtl/albm_checker.sv]
// Port-level checks for the ambient light brightness map, bound to the top level.
// Depends only on the top-level ports.
`timescale 1ns / 1ps

module albm_checker (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_ready,
  input logic        update_valid,
  input logic [7:0]  brightness,
  input logic [15:0] low_threshold,
  input logic [15:0] high_threshold
);

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(brightness)
      && $stable(low_threshold) && $stable(high_threshold) && $stable(update_valid))
    else $error("stalled result changed");

  // A not-ready reading gives an all-zero transaction
  a_not_ready_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !update_valid |-> brightness == 8'd0 && low_threshold == 16'd0
      && high_threshold == 16'd0)
    else $error("not-ready result not cleared");

  // A fresh result has a clamped level and an ordered window
  a_update_range: assert property (@(posedge clk) disable iff (rst)
    result_valid && update_valid |-> brightness != 8'd0 && low_threshold <= high_threshold)
    else $error("update result out of range");

endmodule

bind ambient_light_brightness_map albm_checker u_albm_checker (
  .clk            (clk),
  .rst            (rst),
  .result_valid   (result_valid),
  .result_ready   (result_ready),
  .update_valid   (update_valid),
  .brightness     (brightness),
  .low_threshold  (low_threshold),
  .high_threshold (high_threshold)
);

[sim/ambient_light_brightness_map_tb.sv]
// Testbench for ambient_light_brightness_map: directed table then random readings,
// each result checked against a table value or a fixed-point brightness and window predictor.
// Depends on albm_pkg and the ambient_light_brightness_map RTL.
`timescale 1ns / 1ps

module ambient_light_brightness_map_tb;
  import albm_pkg::*;

  localparam int LOG_ENTRIES   = 32;
  localparam int RANDOM_ITEMS  = 225;
  localparam int NUM_PHASES    = 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int NUM_DIRECTED  = 22;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam longint ONE_Q32   = 64'sd1 <<< 32;

  typedef struct packed {
    logic        upd;
    logic [7:0]  bright;
    logic [15:0] low;
    logic [15:0] high;
  } update_t;

  typedef struct packed {
    logic [15:0] count;
    logic [1:0]  status;
    logic        typed;
    update_t     want;
  } row_t;

  typedef struct packed {
    logic [15:0] count;
    logic [1:0]  status;
    update_t     want;
  } reading_t;

  localparam update_t NO_UPDATE    = '0;
  localparam update_t FULL_UPDATE  = '{1'b1, 8'd255, 16'd52428, 16'd65535};
  localparam update_t FLOOR_UPDATE = '{1'b1, 8'd1, 16'd8, 16'd11};

  // Reset configuration: the typed rows follow from it directly
  row_t directed_rows [NUM_DIRECTED] = '{
    '{16'd1000,  STATUS_VALID,      1'b1, '{1'b1, 8'd255, 16'd800, 16'd1100}},
    '{16'd0,     STATUS_VALID,      1'b1, FLOOR_UPDATE},
    '{16'd9,     STATUS_VALID,      1'b1, FLOOR_UPDATE},
    '{16'd10,    STATUS_VALID,      1'b1, FLOOR_UPDATE},
    '{16'd65535, STATUS_NOT_READY,  1'b1, NO_UPDATE},
    '{16'd0,     STATUS_NOT_READY,  1'b1, NO_UPDATE},
    '{16'd1234,  STATUS_SATURATION, 1'b1, FULL_UPDATE},
    '{16'd0,     STATUS_OVERFLOW,   1'b1, FULL_UPDATE},
    '{16'd65535, STATUS_VALID,      1'b1, FULL_UPDATE},
    '{16'd11,    STATUS_VALID,      1'b0, NO_UPDATE},
    '{16'd1,     STATUS_VALID,      1'b0, NO_UPDATE},
    '{16'd2,     STATUS_VALID,      1'b0, NO_UPDATE},
    '{16'd367,   STATUS_VALID,      1'b0, NO_UPDATE},
    '{16'd368,   STATUS_VALID,      1'b0, NO_UPDATE},
    '{16'd999,   STATUS_VALID,      1'b0, NO_UPDATE},
    '{16'd1001,  STATUS_VALID,      1'b0, NO_UPDATE},
    '{16'd32767, STATUS_VALID,      1'b0, NO_UPDATE},
    '{16'd32768, STATUS_VALID,      1'b0, NO_UPDATE},
    '{16'd59578, STATUS_VALID,      1'b0, NO_UPDATE},
    '{16'd59579, STATUS_VALID,      1'b0, NO_UPDATE},
    '{16'd43690, STATUS_VALID,      1'b0, NO_UPDATE},
    '{16'd21845, STATUS_VALID,      1'b0, NO_UPDATE}
  };

  logic [7:0]  phase_max [NUM_PHASES] = '{8'd255, 8'd1, 8'd1, 8'd200, 8'd255, 8'd0, 8'd0,
                                          8'd255};
  logic [7:0]  phase_min [NUM_PHASES] = '{8'd0, 8'd0, 8'd255, 8'd50, 8'd255, 8'd0, 8'd0,
                                          8'd30};
  logic [15:0] phase_fs  [NUM_PHASES] = '{16'd1, 16'd65535, 16'd1000, 16'd0, 16'd65535,
                                          16'd0, 16'd0, 16'd1000};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  logic [15:0] light_count = '0;
  logic [1:0]  reading_status = STATUS_VALID;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic        update_valid;
  logic [7:0]  brightness;
  logic [15:0] low_threshold;
  logic [15:0] high_threshold;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_MAX_LEVEL;
  logic [15:0] cfg_data = '0;

  logic [7:0]  cur_max_level;
  logic [7:0]  cur_min_level;
  logic [15:0] cur_full_scale;
  longint      frac_rom [LOG_ENTRIES + 1];

  reading_t    pending_updates [$];
  reading_t    oldest;
  int          error_count = 0;
  int          readings_sent = 0;
  int          updates_seen = 0;
  int          stall_left = 0;
  int          cycle_count = 0;
  bit          tx_quiet = 1'b0;
  bit          rx_quiet = 1'b0;
  logic        hold_off = 1'b0;

  ambient_light_brightness_map #(
    .LOG_TABLE_ENTRIES(LOG_ENTRIES)
  ) DUT (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .light_count    (light_count),
    .reading_status (reading_status),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .update_valid   (update_valid),
    .brightness     (brightness),
    .low_threshold  (low_threshold),
    .high_threshold (high_threshold),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // log2(1 + i/N) in Q16, rounded to nearest from a 20-bit bitwise log
  function automatic longint frac_point(int i);
    longint unsigned x;
    longint unsigned acc;
    longint unsigned iv;
    if (i >= LOG_ENTRIES) return 65536;
    iv = i;
    x = (64'd1 << 30) + ((iv << 30) / LOG_ENTRIES);
    acc = 0;
    for (int b = 0; b < 20; b++) begin
      x = (x * x) >> 30;
      acc = acc << 1;
      if (x >= (64'd1 << 31)) begin
        acc = acc | 64'd1;
        x = x >> 1;
      end
    end
    return longint'((acc + 64'd8) >> 4);
  endfunction

  function automatic longint log2_q16(int unsigned v);
    int msb;
    longint unsigned m, f, pos, idx, rem, span;
    longint lo, hi;
    msb = 0;
    for (int k = 0; k < 32; k++)
      if (v[k]) msb = k;
    m = v;
    m = m << (31 - msb);
    f = m - (64'd1 << 31);
    pos = f * LOG_ENTRIES;
    idx = pos >> 31;
    rem = pos - (idx << 31);
    if (idx >= LOG_ENTRIES) begin
      idx = LOG_ENTRIES - 1;
      rem = (64'd1 << 31) - 1;
    end
    lo = frac_rom[idx];
    hi = frac_rom[idx + 1];
    span = hi - lo;
    return longint'(msb) * 65536 + lo + longint'((span * rem) >> 31);
  endfunction

  function automatic update_t predict_update(logic [15:0] count_in, logic [1:0] status);
    update_t     r;
    int unsigned c;
    int unsigned fs;
    int unsigned upper;
    longint      d, v;
    r = NO_UPDATE;
    if (status == STATUS_NOT_READY) return r;
    c = (status == STATUS_SATURATION || status == STATUS_OVERFLOW) ? FULL_COUNT : count_in;
    if (c < MIN_COUNT) c = MIN_COUNT;
    upper = c + c / 10;
    r.upd  = 1'b1;
    r.low  = 16'(c - c / 5);
    r.high = (upper > FULL_COUNT) ? FULL_COUNT : 16'(upper);
    fs = (cur_full_scale == 0) ? 1 : cur_full_scale;
    d = log2_q16(c) - log2_q16(fs);
    v = d * longint'(LN2_Q16) + ONE_Q32;
    v = v * (longint'(cur_max_level) - longint'(cur_min_level))
        + longint'(cur_min_level) * ONE_Q32;
    if (v < ONE_Q32)
      r.bright = 8'd1;
    else if (v >= 255 * ONE_Q32)
      r.bright = 8'd255;
    else
      r.bright = v[39:32];
    return r;
  endfunction

  task automatic flag_error(string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic compare_field(string field, int got, int want, reading_t r);
    if (got != want)
      flag_error($sformatf("%s got %0d want %0d (count %0d status %0d)",
                           field, got, want, r.count, r.status));
  endtask

  // Leaves item_valid high on return; a gap before the next transaction or a drain drops it
  task automatic send_reading(logic [15:0] cnt, logic [1:0] st, logic typed, update_t want);
    int       gap;
    reading_t r;
    gap = (tx_quiet || hold_off) ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid     <= 1'b1;
    light_count    <= cnt;
    reading_status <= st;
    do @(posedge clk); while (!item_ready);
    r.count  = cnt;
    r.status = st;
    r.want   = typed ? want : predict_update(cnt, st);
    pending_updates.push_back(r);
    readings_sent++;
    if (readings_sent % 50 == 0) tx_quiet = ($urandom_range(0, 3) == 0);
  endtask

  // Leaves cfg_valid high on return; the caller drops it after the last write
  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MAX_LEVEL:        cur_max_level = value[7:0];
      REG_MIN_LEVEL:        cur_min_level = value[7:0];
      REG_FULL_SCALE_COUNT: cur_full_scale = value;
      default: ;
    endcase
  endtask

  task automatic drain;
    item_valid <= 1'b0;
    while (pending_updates.size() != 0) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_count();
    int t;
    case ($urandom_range(0, 5))
      1: t = $urandom_range(0, 20);
      2: t = int'(cur_full_scale) + $urandom_range(0, 8) - 4;
      3: t = (1 << $urandom_range(0, 15)) + $urandom_range(0, 2) - 1;
      4: t = $urandom_range(59000, 65535);
      default: t = $urandom_range(0, 65535);
    endcase
    if (t < 0) t = 0;
    return t[15:0];
  endfunction

  function automatic logic [1:0] pick_status();
    case ($urandom_range(0, 9))
      7: return STATUS_NOT_READY;
      8: return STATUS_SATURATION;
      9: return STATUS_OVERFLOW;
      default: return STATUS_VALID;
    endcase
  endfunction

  initial begin
    logic [7:0]  m, n;
    logic [15:0] fs;
    for (int i = 0; i <= LOG_ENTRIES; i++) frac_rom[i] = frac_point(i);
    cur_max_level  = MAX_LEVEL_RESET;
    cur_min_level  = MIN_LEVEL_RESET;
    cur_full_scale = FULL_SCALE_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_reading(directed_rows[i].count, directed_rows[i].status,
                   directed_rows[i].typed, directed_rows[i].want);

    for (int p = 0; p < NUM_PHASES; p++) begin
      drain();
      m  = phase_max[p];
      n  = phase_min[p];
      fs = phase_fs[p];
      if (p == 5 || p == 6) begin
        m  = 8'($urandom_range(1, 255));
        n  = 8'($urandom_range(0, 255));
        fs = 16'($urandom_range(1, 65535));
      end
      // upper data bits are don't-care for the 8-bit levels
      write_reg(REG_MAX_LEVEL, {8'($urandom_range(0, 255)), m});
      write_reg(REG_MIN_LEVEL, {8'($urandom_range(0, 255)), n});
      write_reg(REG_FULL_SCALE_COUNT, fs);
      if (p == 0) write_reg(REG_UNUSED, 16'($urandom_range(0, 65535)));
      cfg_valid <= 1'b0;
      for (int k = 0; k < RANDOM_ITEMS; k++)
        send_reading(pick_count(), pick_status(), 1'b0, NO_UPDATE);
    end

    drain();
    repeat (20) @(posedge clk);
    if (error_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // Long receiver hold-off while the sender keeps offering, to fill the pipeline
  initial begin
    while (readings_sent < 300) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    if (result_valid && result_ready) begin
      updates_seen++;
      if (updates_seen % 50 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
      stall_left = rx_quiet ? 0 : $urandom_range(0, 16);
    end
    if (rst || hold_off) begin
      result_ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (pending_updates.size() == 0) begin
        flag_error($sformatf("unexpected result brightness %0d low %0d high %0d",
                             brightness, low_threshold, high_threshold));
      end else begin
        oldest = pending_updates.pop_front();
        compare_field("update_valid", update_valid, oldest.want.upd, oldest);
        compare_field("brightness", brightness, oldest.want.bright, oldest);
        compare_field("low_threshold", low_threshold, oldest.want.low, oldest);
        compare_field("high_threshold", high_threshold, oldest.want.high, oldest);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

endmodule
